// ===== design/pmkid_cache_table_defines.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef PMKID_CACHE_TABLE_DEFINES_SVH
`define PMKID_CACHE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define PMKID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMKID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pmkid_pkg.sv =====
`timescale 1ns / 1ps

package pmkid_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 3'd0,
    MODE_LOOKUP = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_FLUSH  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BSSID = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // table write/maintenance command
  typedef struct packed {
    logic  we_addr;
    logic  we_key;
    logic  set_vld;
    logic  clr_vld;
    logic  flush;
    idx_t  idx;
    addr_t addr;
    key_t  key_high;
    key_t  key_low;
  } wr_t;

  // registered read of one entry
  typedef struct packed {
    logic  vld;
    addr_t addr;
    key_t  key_high;
    key_t  key_low;
  } rd_t;

  typedef struct packed {
    status_e status;
    logic    found;
    idx_t    idx;
    key_t    key_high;
    key_t    key_low;
  } res_t;

  function automatic idx_t wrap_next(idx_t i);
    return (i == idx_t'(ENTRIES - 1)) ? idx_t'(0) : idx_t'(i + 1'b1);
  endfunction

endpackage

// ===== design/pmkid_cache_table.sv =====
`timescale 1ns / 1ps
// Flush, rejected and unknown modes give their result without a scan; other requests
//   compare the entries in index order (one compare per cycle) up to a match or the last entry.
// The serial entry scan holds off a new request until the previous result has left the sequencer.
// A result waits in an output register while the next request is scanned.
// Reset: table empty (per-entry valid bits cleared at once), fill pointer 0, no clearing pass.

module pmkid_cache_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [pmkid_pkg::MODE_W-1:0] mode_i,
  input  logic [pmkid_pkg::ADDR_W-1:0] bssid_i,
  input  logic [pmkid_pkg::KEY_W-1:0]  key_high_i,
  input  logic [pmkid_pkg::KEY_W-1:0]  key_low_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pmkid_pkg::STATUS_W-1:0] status_o,
  output logic                         found_o,
  output logic [pmkid_pkg::INDEX_W-1:0] entry_index_o,
  output logic [pmkid_pkg::KEY_W-1:0]  found_key_high_o,
  output logic [pmkid_pkg::KEY_W-1:0]  found_key_low_o
);

  pmkid_pkg::idx_t rd_idx;
  pmkid_pkg::rd_t  rd;
  pmkid_pkg::wr_t  wr;
  pmkid_pkg::res_t res;
  logic            res_valid;
  logic            res_ready;

  logic                           out_valid_q;
  logic [pmkid_pkg::STATUS_W-1:0] status_q;
  logic                           found_q;
  pmkid_pkg::index_t              index_q;
  pmkid_pkg::key_t                okh_q;
  pmkid_pkg::key_t                okl_q;

  pmkid_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .bssid_i     (bssid_i),
    .key_high_i  (key_high_i),
    .key_low_i   (key_low_i),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd),
    .wr_o        (wr),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pmkid_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .wr_i     (wr),
    .rd_o     (rd)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      status_q <= res.status;
      found_q  <= res.found;
      index_q  <= pmkid_pkg::index_t'(res.idx);
      okh_q    <= res.key_high;
      okl_q    <= res.key_low;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign entry_index_o    = index_q;
  assign found_key_high_o = okh_q;
  assign found_key_low_o  = okl_q;

endmodule

// ===== design/pmkid_store.sv =====
`timescale 1ns / 1ps

module pmkid_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmkid_pkg::idx_t    rd_idx_i,
  input  pmkid_pkg::wr_t     wr_i,
  output pmkid_pkg::rd_t     rd_o
);

  logic [pmkid_pkg::ENTRIES-1:0] vld_q;
  logic                          rd_vld_q;

  pmkid_pkg::addr_t addr_mem [pmkid_pkg::ENTRIES];
  pmkid_pkg::key_t  kh_mem   [pmkid_pkg::ENTRIES];
  pmkid_pkg::key_t  kl_mem   [pmkid_pkg::ENTRIES];

  pmkid_pkg::addr_t rd_addr_q;
  pmkid_pkg::key_t  rd_kh_q;
  pmkid_pkg::key_t  rd_kl_q;

  // an invalid entry reads with its valid bit low, so it never matches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_idx_i];
      if (wr_i.flush) begin
        vld_q <= '0;
      end else begin
        if (wr_i.set_vld) vld_q[wr_i.idx] <= 1'b1;
        if (wr_i.clr_vld) vld_q[wr_i.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we_addr) addr_mem[wr_i.idx] <= wr_i.addr;
    if (wr_i.we_key) begin
      kh_mem[wr_i.idx] <= wr_i.key_high;
      kl_mem[wr_i.idx] <= wr_i.key_low;
    end
    rd_addr_q <= addr_mem[rd_idx_i];
    rd_kh_q   <= kh_mem[rd_idx_i];
    rd_kl_q   <= kl_mem[rd_idx_i];
  end

  assign rd_o.vld      = rd_vld_q;
  assign rd_o.addr     = rd_addr_q;
  assign rd_o.key_high = rd_kh_q;
  assign rd_o.key_low  = rd_kl_q;

endmodule

// ===== design/pmkid_seq.sv =====
`timescale 1ns / 1ps
`include "pmkid_cache_table_defines.svh"

module pmkid_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pmkid_pkg::MODE_W-1:0]     mode_i,
  input  pmkid_pkg::addr_t                 bssid_i,
  input  pmkid_pkg::key_t                  key_high_i,
  input  pmkid_pkg::key_t                  key_low_i,
  output pmkid_pkg::idx_t                  rd_idx_o,
  input  pmkid_pkg::rd_t                   rd_i,
  output pmkid_pkg::wr_t                   wr_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output pmkid_pkg::res_t                  res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  pmkid_pkg::idx_t        scan_idx_q, scan_idx_d;
  pmkid_pkg::idx_t        fill_ptr_q, fill_ptr_d;
  pmkid_pkg::mode_e       mode_q, mode_d;
  pmkid_pkg::addr_t       bssid_q, bssid_d;
  pmkid_pkg::key_t        kh_q, kh_d;
  pmkid_pkg::key_t        kl_q, kl_d;
  pmkid_pkg::res_t        res_q, res_d;
  logic                   accept;
  logic                   hit;
  logic                   last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign last        = (scan_idx_q == pmkid_pkg::idx_t'(pmkid_pkg::ENTRIES - 1));
  assign hit         = rd_i.vld && (rd_i.addr == bssid_q);
  assign rd_idx_o    = (state_q == S_SCAN) ? pmkid_pkg::wrap_next(scan_idx_q) : '0;

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    fill_ptr_d = fill_ptr_q;
    mode_d     = mode_q;
    bssid_d    = bssid_q;
    kh_d       = kh_q;
    kl_d       = kl_q;
    res_d      = res_q;

    wr_o          = '0;
    wr_o.idx      = scan_idx_q;
    wr_o.addr     = bssid_q;
    wr_o.key_high = kh_q;
    wr_o.key_low  = kl_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d     = pmkid_pkg::mode_e'(mode_i);
          bssid_d    = bssid_i;
          kh_d       = key_high_i;
          kl_d       = key_low_i;
          scan_idx_d = '0;
          res_d      = '0;
          state_d    = S_DONE;
          unique case (pmkid_pkg::mode_e'(mode_i)) inside
            pmkid_pkg::MODE_FLUSH: begin
              wr_o.flush = 1'b1;
              fill_ptr_d = '0;
            end
            pmkid_pkg::MODE_SET, pmkid_pkg::MODE_LOOKUP, pmkid_pkg::MODE_REMOVE: begin
              if (bssid_i == '0) res_d.status = pmkid_pkg::ST_BAD_BSSID;
              else               state_d      = S_SCAN;
            end
            pmkid_pkg::MODE_DELETE: begin
              if (fill_ptr_q == '0)   res_d.status = pmkid_pkg::ST_EMPTY;
              else if (bssid_i == '0) res_d.status = pmkid_pkg::ST_BAD_BSSID;
              else                    state_d      = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_d.found = 1'b1;
          res_d.idx   = scan_idx_q;
          state_d     = S_DONE;
          unique case (mode_q)
            pmkid_pkg::MODE_SET: begin
              wr_o.we_key = 1'b1;
              fill_ptr_d  = pmkid_pkg::wrap_next(scan_idx_q);
            end
            pmkid_pkg::MODE_LOOKUP: begin
              res_d.key_high = rd_i.key_high;
              res_d.key_low  = rd_i.key_low;
            end
            pmkid_pkg::MODE_DELETE: begin
              wr_o.clr_vld = 1'b1;
            end
            pmkid_pkg::MODE_REMOVE: begin
              wr_o.we_key   = 1'b1;
              wr_o.key_high = '0;
              wr_o.key_low  = '0;
              fill_ptr_d    = (fill_ptr_q == '0) ? '0 : fill_ptr_q - 1'b1;
            end
            default: ;
          endcase
        end else if (last) begin
          state_d = S_DONE;
          if (mode_q == pmkid_pkg::MODE_SET) begin
            wr_o.we_addr = 1'b1;
            wr_o.we_key  = 1'b1;
            wr_o.set_vld = 1'b1;
            wr_o.idx     = fill_ptr_q;
            res_d.idx    = fill_ptr_q;
            fill_ptr_d   = pmkid_pkg::wrap_next(fill_ptr_q);
          end else begin
            res_d.status = pmkid_pkg::ST_NOT_FOUND;
          end
        end else begin
          scan_idx_d = pmkid_pkg::wrap_next(scan_idx_q);
        end
      end

      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
      fill_ptr_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      fill_ptr_q <= fill_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    bssid_q <= bssid_d;
    kh_q    <= kh_d;
    kl_q    <= kl_d;
    res_q   <= res_d;
  end

  `PMKID_ASSERT_IMP(a_scan_in_range, state_q == S_SCAN,
    scan_idx_q <= pmkid_pkg::idx_t'(pmkid_pkg::ENTRIES - 1), "scan index out of range")
  `PMKID_ASSERT_IMP(a_ptr_in_range, 1'b1,
    fill_ptr_q <= pmkid_pkg::idx_t'(pmkid_pkg::ENTRIES - 1), "fill pointer out of range")
  `PMKID_ASSERT_IMP(a_flush_alone, wr_o.flush,
    !(wr_o.we_addr || wr_o.we_key || wr_o.set_vld || wr_o.clr_vld), "flush mixed with write")
  `PMKID_ASSERT_NXT(a_flush_ptr, accept && (mode_i == pmkid_pkg::MODE_FLUSH),
    fill_ptr_q == '0, "flush left pointer set")
  `PMKID_ASSERT_NXT(a_res_hold, (state_q == S_DONE) && !res_ready_i,
    (state_q == S_DONE) && $stable(res_q), "pending result lost")

endmodule

// ===== dv/pmkid_table_checker.sv =====
`timescale 1ns / 1ps

module pmkid_table_checker
  import pmkid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [MODE_W-1:0]   mode_i,
  input  addr_t               bssid_i,
  input  key_t                key_high_i,
  input  key_t                key_low_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic                found_i,
  input  index_t              entry_index_i,
  input  key_t                found_key_high_i,
  input  key_t                found_key_low_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  hits_o
);

  typedef struct packed {
    status_e status;
    logic    found;
    index_t  index;
    key_t    key_high;
    key_t    key_low;
  } table_answer_t;

  table_answer_t answers_due[$];

  addr_t tbl_addr   [ENTRIES];
  key_t  tbl_key_hi [ENTRIES];
  key_t  tbl_key_lo [ENTRIES];
  logic  tbl_live   [ENTRIES];
  idx_t  fill_ptr;

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_addr[i]   = '0;
      tbl_key_hi[i] = '0;
      tbl_key_lo[i] = '0;
      tbl_live[i]   = 1'b0;
    end
    fill_ptr = '0;
  endfunction

  function automatic idx_t next_slot(idx_t p);
    return (p == idx_t'(ENTRIES - 1)) ? idx_t'(0) : idx_t'(p + 1);
  endfunction

  // first matching address in index order, -1 on a miss
  function automatic int match_slot(addr_t a);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_addr[i] == a) return i;
    end
    return -1;
  endfunction

  function automatic table_answer_t predict_answer(logic [MODE_W-1:0] m, addr_t a,
                                                   key_t kh, key_t kl);
    table_answer_t ans;
    int hit;
    idx_t slot;
    ans = '0;
    ans.status = ST_OK;
    hit = match_slot(a);
    case (m)
      MODE_SET: begin
        if (a == '0) begin
          ans.status = ST_BAD_BSSID;
        end else begin
          if (hit >= 0) begin
            slot = idx_t'(hit);
            ans.found = 1'b1;
          end else begin
            slot = fill_ptr;
            tbl_addr[slot] = a;
          end
          tbl_key_hi[slot] = kh;
          tbl_key_lo[slot] = kl;
          tbl_live[slot]   = 1'b1;
          fill_ptr  = next_slot(slot);
          ans.index = index_t'(slot);
        end
      end
      MODE_LOOKUP: begin
        if (a == '0) begin
          ans.status = ST_BAD_BSSID;
        end else if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          ans.found    = 1'b1;
          ans.index    = index_t'(hit);
          ans.key_high = tbl_key_hi[hit];
          ans.key_low  = tbl_key_lo[hit];
        end
      end
      MODE_DELETE: begin
        if (fill_ptr == '0) begin
          ans.status = ST_EMPTY;
        end else if (a == '0) begin
          ans.status = ST_BAD_BSSID;
        end else if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          tbl_addr[hit]   = '0;
          tbl_key_hi[hit] = '0;
          tbl_key_lo[hit] = '0;
          tbl_live[hit]   = 1'b0;
          ans.found = 1'b1;
          ans.index = index_t'(hit);
        end
      end
      MODE_REMOVE: begin
        if (a == '0) begin
          ans.status = ST_BAD_BSSID;
        end else if (hit < 0) begin
          ans.status = ST_NOT_FOUND;
        end else begin
          // key only; address and live flag stay, pointer steps back unless at 0
          tbl_key_hi[hit] = '0;
          tbl_key_lo[hit] = '0;
          if (fill_ptr != '0) fill_ptr = fill_ptr - 1'b1;
          ans.found = 1'b1;
          ans.index = index_t'(hit);
        end
      end
      MODE_FLUSH: clear_table();
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_answer_t want;
    if (!rst_ni) begin
      clear_table();
      answers_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      hits_o       = 0;
    end else begin
      // a result never belongs to a request taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("result with no request pending");
          fail_count_o++;
        end else begin
          want = answers_due.pop_front();
          checked_o++;
          if (found_i === 1'b1) hits_o++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_i);
            fail_count_o++;
          end
          if (entry_index_i !== want.index) begin
            $error("entry_index: expected %0d, got %0d", want.index, entry_index_i);
            fail_count_o++;
          end
          if (found_key_high_i !== want.key_high) begin
            $error("found_key_high: expected %h, got %h", want.key_high, found_key_high_i);
            fail_count_o++;
          end
          if (found_key_low_i !== want.key_low) begin
            $error("found_key_low: expected %h, got %h", want.key_low, found_key_low_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        answers_due.push_back(predict_answer(mode_i, bssid_i, key_high_i, key_low_i));
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== dv/tb_pmkid_cache_table.sv =====
`timescale 1ns / 1ps

module tb_pmkid_cache_table;
  import pmkid_pkg::*;

  localparam int RANDOM_REQS = 650;
  localparam int POOL_SIZE   = 20;

  logic                clk;
  logic                rst_n;
  logic                req_valid;
  logic                req_ready;
  logic [MODE_W-1:0]   req_mode;
  addr_t               req_bssid;
  key_t                req_key_hi;
  key_t                req_key_lo;
  logic                rsp_valid;
  logic                rsp_ready;
  logic [STATUS_W-1:0] rsp_status;
  logic                rsp_found;
  index_t              rsp_index;
  key_t                rsp_key_hi;
  key_t                rsp_key_lo;

  int fail_count, pending, checked, hits;
  int burst_left, sent, n_directed;
  addr_t pool [POOL_SIZE];

  pmkid_cache_table dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (req_valid),
    .in_ready_o       (req_ready),
    .mode_i           (req_mode),
    .bssid_i          (req_bssid),
    .key_high_i       (req_key_hi),
    .key_low_i        (req_key_lo),
    .out_valid_o      (rsp_valid),
    .out_ready_i      (rsp_ready),
    .status_o         (rsp_status),
    .found_o          (rsp_found),
    .entry_index_o    (rsp_index),
    .found_key_high_o (rsp_key_hi),
    .found_key_low_o  (rsp_key_lo)
  );

  pmkid_table_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (req_valid),
    .in_ready_i       (req_ready),
    .mode_i           (req_mode),
    .bssid_i          (req_bssid),
    .key_high_i       (req_key_hi),
    .key_low_i        (req_key_lo),
    .out_valid_i      (rsp_valid),
    .out_ready_i      (rsp_ready),
    .status_i         (rsp_status),
    .found_i          (rsp_found),
    .entry_index_i    (rsp_index),
    .found_key_high_i (rsp_key_hi),
    .found_key_low_i  (rsp_key_lo),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .hits_o           (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic addr_t rand_addr();
    addr_t a;
    do a = addr_t'({$urandom, $urandom}); while (a == '0);
    return a;
  endfunction

  function automatic key_t rand_key();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(input logic [MODE_W-1:0] m, input addr_t a,
                          input key_t kh, input key_t kl);
    int gap;
    req_valid  = 1'b1;
    req_mode   = m;
    req_bssid  = a;
    req_key_hi = kh;
    req_key_lo = kl;
    do @(posedge clk); while (!req_ready);
    sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid = 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // receiver: stretches of always-ready, random, mostly-stalled and toggling
  initial begin
    int style, span;
    rsp_ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0:       rsp_ready = 1'b1;
          1:       rsp_ready = 1'($urandom_range(0, 1));
          2:       rsp_ready = ($urandom_range(0, 9) == 0);
          default: rsp_ready = ~rsp_ready;
        endcase
      end
    end
  end

  initial begin
    int pick;
    addr_t a;
    logic [MODE_W-1:0] m;
    rst_n      = 1'b0;
    req_valid  = 1'b0;
    req_mode   = '0;
    req_bssid  = '0;
    req_key_hi = '0;
    req_key_lo = '0;
    burst_left = 0;
    sent       = 0;
    foreach (pool[i]) pool[i] = rand_addr();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_req(MODE_DELETE, addr_t'(1), '0, '0);         // pointer at 0: empty
    send_req(MODE_LOOKUP, '0, '0, '0);
    send_req(MODE_SET, '0, '1, '1);
    send_req(MODE_SET, '1, '1, '1);
    send_req(MODE_SET, addr_t'(1), '0, '0);
    send_req(MODE_LOOKUP, '1, '0, '0);
    send_req(MODE_LOOKUP, addr_t'(48'h123), '0, '0);
    send_req(MODE_SET, '1, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);  // renew
    send_req(MODE_LOOKUP, '1, '0, '0);
    send_req(MODE_REMOVE, addr_t'(1), '1, '1);
    send_req(MODE_REMOVE, addr_t'(1), '1, '1);         // pointer saturates
    send_req(MODE_LOOKUP, addr_t'(1), '1, '1);
    send_req(MODE_DELETE, '1, '0, '0);                 // empty despite entries
    send_req(MODE_SET, addr_t'(48'h5555_5555_5555), rand_key(), rand_key());
    send_req(MODE_SET, addr_t'(48'hAAAA_AAAA_AAAA), rand_key(), rand_key());
    send_req(MODE_DELETE, '0, '0, '0);
    send_req(MODE_DELETE, addr_t'(48'h777), '0, '0);
    send_req(MODE_DELETE, addr_t'(48'hAAAA_AAAA_AAAA), '0, '0);
    send_req(MODE_REMOVE, '0, '0, '0);
    send_req(MODE_REMOVE, addr_t'(48'h777), '0, '0);
    for (int u = MODE_FLUSH + 1; u < (1 << MODE_W); u++) begin
      send_req(MODE_W'(u), rand_addr(), rand_key(), rand_key());
    end
    send_req(MODE_FLUSH, rand_addr(), rand_key(), rand_key());
    send_req(MODE_LOOKUP, addr_t'(48'h5555_5555_5555), '0, '0);
    n_directed = sent;

    // mostly traffic on a small address pool so entries hit, renew and evict
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      a = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick < 35) m = MODE_SET;
      else if (pick < 62) m = MODE_LOOKUP;
      else if (pick < 74) m = MODE_DELETE;
      else if (pick < 86) m = MODE_REMOVE;
      else if (pick < 88) m = MODE_FLUSH;
      else if (pick < 91) begin
        m = MODE_W'($urandom_range(MODE_FLUSH + 1, (1 << MODE_W) - 1));
        a = rand_addr();
      end else if (pick < 95) begin
        m = MODE_W'($urandom_range(MODE_SET, MODE_REMOVE));
        a = '0;
      end else begin
        m = MODE_W'($urandom_range(MODE_SET, MODE_REMOVE));
        a = rand_addr();
      end
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = rand_addr();
      send_req(m, a, rand_key(), rand_key());
    end
    req_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (ENTRIES + 8) @(negedge clk);

    $display("%0d requests (%0d directed, rest random over a %0d-address pool)",
             sent, n_directed, POOL_SIZE);
    $display("%0d results checked, %0d found a matching entry", checked, hits);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
